@@ hw/rtl/dvid_pkg.sv @@
package dvid_pkg;

    // Decoder phases, one-hot coded.
    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_TEXT   = 6'b000010,
        PH_LENGTH = 6'b000100,
        PH_FIRST  = 6'b001000,
        PH_SECOND = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    // Codes of the result kind field.
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Mask for one length nibble.
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    // Width of the decoded identifier.
    localparam int VALUE_W = 128;

endpackage

@@ hw/rtl/delta_varlen_id_decoder_top.sv @@
// Channel   Handshake                  Payload
// input     byte_valid / byte_stall    in_byte
// result    result_valid / result_stall result_kind, text_byte, value_low,
//                                      value_high, list_end
//
// One byte is accepted per cycle while the result register is free; a byte waits
// in the input register, and its result is then loaded into the result register.
// The critical path is the delta byte shift-in followed by one 128-bit add.
// rst_n clears all decoder state asynchronously; the stream restarts at the header.
// A stalled result holds the pipeline; bytes that give no result also wait for
// the result register to be free, so the input stalls only while a result waits.
module delta_varlen_id_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  text_byte,
    output logic [63:0] value_low,
    output logic [63:0] value_high,
    output logic        list_end
);

    // Input register.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;

    // Decoder state.
    dvid_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  header_count_reg, header_count_next;
    logic [31:0] text_left_reg, text_left_next;
    logic [63:0] previous_low_reg, previous_low_next;
    logic [63:0] previous_high_reg, previous_high_next;
    logic [63:0] gather_low_reg, gather_low_next;
    logic [63:0] gather_high_reg, gather_high_next;
    logic [3:0]  gather_position_reg, gather_position_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [3:0]  second_length_reg, second_length_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [7:0]  text_reg, text_next;
    logic [63:0] vlow_reg, vlow_next;
    logic [63:0] vhigh_reg, vhigh_next;
    logic        end_reg, end_next;

    logic        can_load;
    logic        fire;

    // Working values for the current byte.
    logic [3:0]  low_len;
    logic [3:0]  high_len;
    logic [31:0] header_value;
    logic [63:0] byte_shifted;
    logic [63:0] gl_in;
    logic [63:0] gh_in;
    logic [3:0]  bytes_dec;
    logic [dvid_pkg::VALUE_W-1:0] sum;

    // The result register is free when empty or being taken this cycle.
    assign can_load   = !out_valid_reg || !result_stall;
    assign fire       = s1_valid_reg && can_load;
    assign byte_stall = s1_valid_reg && !can_load;

    assign low_len  = 4'(s1_byte_reg & dvid_pkg::NIBBLE_MASK);
    assign high_len = 4'(s1_byte_reg >> 4);

    assign header_value = text_left_reg
                          | (32'(s1_byte_reg) << {header_count_reg, 3'b000});

    // Shift the delta byte into its place in the gathered word.
    assign byte_shifted = 64'(s1_byte_reg) << {gather_position_reg[2:0], 3'b000};
    assign gl_in = gather_position_reg[3] ? gather_low_reg : (gather_low_reg | byte_shifted);
    assign gh_in = gather_position_reg[3] ? (gather_high_reg | byte_shifted) : gather_high_reg;
    assign bytes_dec = bytes_left_reg - 4'd1;
    assign sum = {previous_high_reg, previous_low_reg} + {gh_in, gl_in};

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        text_left_next       = text_left_reg;
        previous_low_next    = previous_low_reg;
        previous_high_next   = previous_high_reg;
        gather_low_next      = gather_low_reg;
        gather_high_next     = gather_high_reg;
        gather_position_next = gather_position_reg;
        bytes_left_next      = bytes_left_reg;
        second_length_next   = second_length_reg;
        out_valid_next       = out_valid_reg && result_stall;
        kind_next            = kind_reg;
        text_next            = text_reg;
        vlow_next            = vlow_reg;
        vhigh_next           = vhigh_reg;
        end_next             = end_reg;

        if (fire)
        begin
            unique case (phase_reg)
                dvid_pkg::PH_HEADER:
                begin
                    text_left_next    = header_value;
                    header_count_next = header_count_reg + 2'd1;
                    if (header_count_reg == 2'd3)
                    begin
                        phase_next = (header_value == 32'd0) ? dvid_pkg::PH_LENGTH
                                                             : dvid_pkg::PH_TEXT;
                    end
                end
                dvid_pkg::PH_TEXT:
                begin
                    out_valid_next = 1'b1;
                    kind_next      = dvid_pkg::KIND_TEXT;
                    text_next      = s1_byte_reg;
                    vlow_next      = 64'd0;
                    vhigh_next     = 64'd0;
                    end_next       = 1'b0;
                    text_left_next = text_left_reg - 32'd1;
                    if (text_left_reg == 32'd1)
                    begin
                        phase_next = dvid_pkg::PH_LENGTH;
                    end
                end
                dvid_pkg::PH_LENGTH:
                begin
                    if (low_len == 4'd0)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = dvid_pkg::KIND_END;
                        text_next      = 8'd0;
                        vlow_next      = 64'd0;
                        vhigh_next     = 64'd0;
                        end_next       = 1'b1;
                        phase_next     = dvid_pkg::PH_DONE;
                    end
                    else
                    begin
                        second_length_next   = high_len;
                        gather_low_next      = 64'd0;
                        gather_high_next     = 64'd0;
                        gather_position_next = 4'd0;
                        bytes_left_next      = low_len;
                        phase_next           = dvid_pkg::PH_FIRST;
                    end
                end
                dvid_pkg::PH_FIRST,
                dvid_pkg::PH_SECOND:
                begin
                    gather_low_next      = gl_in;
                    gather_high_next     = gh_in;
                    gather_position_next = gather_position_reg + 4'd1;
                    bytes_left_next      = bytes_dec;
                    if (bytes_dec == 4'd0)
                    begin
                        // Delta complete: accumulate and emit the value.
                        previous_low_next  = sum[63:0];
                        previous_high_next = sum[127:64];
                        out_valid_next     = 1'b1;
                        kind_next          = dvid_pkg::KIND_VALUE;
                        text_next          = 8'd0;
                        vlow_next          = sum[63:0];
                        vhigh_next         = sum[127:64];
                        end_next           = 1'b0;
                        if (phase_reg == dvid_pkg::PH_SECOND)
                        begin
                            phase_next = dvid_pkg::PH_LENGTH;
                        end
                        else if (second_length_reg == 4'd0)
                        begin
                            end_next   = 1'b1;
                            phase_next = dvid_pkg::PH_DONE;
                        end
                        else
                        begin
                            gather_low_next      = 64'd0;
                            gather_high_next     = 64'd0;
                            gather_position_next = 4'd0;
                            bytes_left_next      = second_length_reg;
                            phase_next           = dvid_pkg::PH_SECOND;
                        end
                    end
                end
                dvid_pkg::PH_DONE:
                begin
                    // Bytes after the end of the list are dropped.
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Input register: load when empty or when its byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // Decoder state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= dvid_pkg::PH_HEADER;
            header_count_reg    <= 2'd0;
            text_left_reg       <= 32'd0;
            previous_low_reg    <= 64'd0;
            previous_high_reg   <= 64'd0;
            gather_low_reg      <= 64'd0;
            gather_high_reg     <= 64'd0;
            gather_position_reg <= 4'd0;
            bytes_left_reg      <= 4'd0;
            second_length_reg   <= 4'd0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            header_count_reg    <= header_count_next;
            text_left_reg       <= text_left_next;
            previous_low_reg    <= previous_low_next;
            previous_high_reg   <= previous_high_next;
            gather_low_reg      <= gather_low_next;
            gather_high_reg     <= gather_high_next;
            gather_position_reg <= gather_position_next;
            bytes_left_reg      <= bytes_left_next;
            second_length_reg   <= second_length_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        text_reg  <= text_next;
        vlow_reg  <= vlow_next;
        vhigh_reg <= vhigh_next;
        end_reg   <= end_next;
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = kind_reg;
    assign text_byte    = text_reg;
    assign value_low    = vlow_reg;
    assign value_high   = vhigh_reg;
    assign list_end     = end_reg;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // One result beat as the decoder gives it.
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  text;
        logic [63:0] id_low;
        logic [63:0] id_high;
        logic        closes;
    } id_beat_t;

    // Tracks the decoder state and holds the result beats still owed by it.
    class id_decode_board;
        dvid_pkg::phase_t phase;
        logic [1:0]    header_idx;
        logic [31:0]   text_left;
        logic [127:0]  running_id;
        logic [127:0]  delta;
        logic [3:0]    delta_pos;
        logic [3:0]    delta_left;
        logic [3:0]    second_len;
        id_beat_t      owed_beats[$];
        int            errors;
        int            text_seen;
        int            ids_seen;
        int            ends_seen;

        function new();
            phase      = dvid_pkg::PH_HEADER;
            header_idx = '0;
            text_left  = '0;
            running_id = '0;
            delta      = '0;
            delta_pos  = '0;
            delta_left = '0;
            second_len = '0;
            errors     = 0;
            text_seen  = 0;
            ids_seen   = 0;
            ends_seen  = 0;
        endfunction

        function int pending();
            return owed_beats.size();
        endfunction

        // Appends one beat at the tail of the owed list.
        function void owe_beat(id_beat_t r);
            owed_beats = {owed_beats, r};
        endfunction

        function void start_delta(logic [3:0] count);
            delta      = '0;
            delta_pos  = '0;
            delta_left = count;
        endfunction

        // Shifts one delta byte in; true once the delta is complete.
        function bit shift_delta(logic [7:0] b);
            delta[8 * delta_pos +: 8] = b;
            delta_pos  = delta_pos + 4'd1;
            delta_left = delta_left - 4'd1;
            return delta_left == 4'd0;
        endfunction

        function void owe_id(logic closes);
            id_beat_t r;
            running_id = running_id + delta;
            r.kind    = dvid_pkg::KIND_VALUE;
            r.text    = '0;
            r.id_low  = running_id[63:0];
            r.id_high = running_id[127:64];
            r.closes  = closes;
            owe_beat(r);
        endfunction

        // Works out what an accepted input byte owes.
        function void note_byte(logic [7:0] b);
            id_beat_t r;
            logic [7:0] nib_lo;
            nib_lo = b & dvid_pkg::NIBBLE_MASK;
            case (phase)
                dvid_pkg::PH_HEADER:
                begin
                    text_left[8 * header_idx +: 8] = b;
                    if (header_idx == 2'd3)
                        phase = (text_left == 32'd0) ? dvid_pkg::PH_LENGTH
                                                     : dvid_pkg::PH_TEXT;
                    header_idx = header_idx + 2'd1;
                end
                dvid_pkg::PH_TEXT:
                begin
                    r.kind    = dvid_pkg::KIND_TEXT;
                    r.text    = b;
                    r.id_low  = '0;
                    r.id_high = '0;
                    r.closes  = 1'b0;
                    owe_beat(r);
                    text_left = text_left - 32'd1;
                    if (text_left == 32'd0)
                        phase = dvid_pkg::PH_LENGTH;
                end
                dvid_pkg::PH_LENGTH:
                begin
                    if (nib_lo == 8'd0)
                    begin
                        r.kind    = dvid_pkg::KIND_END;
                        r.text    = '0;
                        r.id_low  = '0;
                        r.id_high = '0;
                        r.closes  = 1'b1;
                        owe_beat(r);
                        phase = dvid_pkg::PH_DONE;
                    end
                    else
                    begin
                        second_len = b[7:4];
                        start_delta(nib_lo[3:0]);
                        phase = dvid_pkg::PH_FIRST;
                    end
                end
                dvid_pkg::PH_FIRST:
                begin
                    if (shift_delta(b))
                    begin
                        if (second_len == 4'd0)
                        begin
                            owe_id(1'b1);
                            phase = dvid_pkg::PH_DONE;
                        end
                        else
                        begin
                            owe_id(1'b0);
                            start_delta(second_len);
                            phase = dvid_pkg::PH_SECOND;
                        end
                    end
                end
                dvid_pkg::PH_SECOND:
                begin
                    if (shift_delta(b))
                    begin
                        owe_id(1'b0);
                        phase = dvid_pkg::PH_LENGTH;
                    end
                end
                default: ;
            endcase
        endfunction

        // Compares one accepted result beat with the oldest one owed.
        function void check_result(logic [1:0] kind, logic [7:0] text, logic [63:0] id_low,
                                   logic [63:0] id_high, logic closes);
            id_beat_t e;
            if (owed_beats.size() == 0)
            begin
                $error("result beat with none owed: kind %0d text %h low %h high %h end %b",
                       kind, text, id_low, id_high, closes);
                errors++;
                return;
            end
            e = owed_beats.pop_front();
            if (kind !== e.kind)
            begin
                $error("result_kind: expected %h, actual %h", e.kind, kind);
                errors++;
            end
            if (text !== e.text)
            begin
                $error("text_byte: expected %h, actual %h", e.text, text);
                errors++;
            end
            if (id_low !== e.id_low)
            begin
                $error("value_low: expected %h, actual %h", e.id_low, id_low);
                errors++;
            end
            if (id_high !== e.id_high)
            begin
                $error("value_high: expected %h, actual %h", e.id_high, id_high);
                errors++;
            end
            if (closes !== e.closes)
            begin
                $error("list_end: expected %b, actual %b", e.closes, closes);
                errors++;
            end
            case (e.kind)
                dvid_pkg::KIND_TEXT:  text_seen++;
                dvid_pkg::KIND_VALUE: ids_seen++;
                default:              ends_seen++;
            endcase
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  in_byte;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  text_byte;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        list_end;

    id_decode_board board;
    int unsigned    beats_in = 0;
    int             stall_left = 0;
    int             stall_draw;
    bit             calm = 1'b0;

    delta_varlen_id_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .in_byte      (in_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .text_byte    (text_byte),
        .value_low    (value_low),
        .value_high   (value_high),
        .list_end     (list_end)
    );

    always #2 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Delta sizes are mostly short, with the full fifteen bytes now and then.
    function automatic logic [3:0] pick_len();
        if ($urandom_range(0, 99) < 80)
            return 4'($urandom_range(1, 4));
        return 4'($urandom_range(5, 15));
    endfunction

    function automatic logic [7:0] pick_delta_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'h00;
        if (r < 30)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Sample both channels at the rising edge; check results before noting the input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                board.check_result(result_kind, text_byte, value_low, value_high, list_end);
            if (byte_valid && !byte_stall)
            begin
                board.note_byte(in_byte);
                beats_in <= beats_in + 1;
            end
        end
    end

    // Receiver back-pressure, switched off during calm stretches.
    always @(negedge clk)
    begin
        if (!rst_n || calm)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            stall_draw = pick_gap();
            result_stall <= (stall_draw != 0);
            stall_left   <= (stall_draw != 0) ? stall_draw - 1 : 0;
        end
    end

    // Offers one byte, after an optional gap, and waits until it is taken.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        int unsigned target;
        gap = calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        target = beats_in + 1;
        byte_valid <= 1'b1;
        in_byte    <= b;
        do
            @(negedge clk);
        while (beats_in < target);
    endtask

    // Holds the sender off until every owed result has come out.
    task automatic drain();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic send_delta(input logic [3:0] count);
        repeat (count) send_byte(pick_delta_byte());
    endtask

    initial
    begin
        #4000000;
        $display("delta_varlen_id_decoder_top regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] text_len;
        logic [3:0]  first_n;
        logic [3:0]  second_n;
        int          next_block;

        board        = new();
        rst_n        = 1'b0;
        byte_valid   = 1'b0;
        in_byte      = 8'h00;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Header: sometimes an empty text, otherwise a short passthrough section
        // that always holds at least the two fixed bytes sent first.
        text_len = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(2, 200));
        for (int i = 0; i < 4; i++)
            send_byte(text_len[8 * i +: 8]);
        if (text_len != 0)
        begin
            send_byte(8'h00);
            send_byte(8'hFF);
            for (int i = 2; i < text_len; i++)
                send_byte(8'($urandom));
        end

        // Directed groups: the smallest and largest delta bytes, then a carry into
        // the upper half from an eight-byte all-ones delta and a full fifteen-byte one.
        send_byte(8'h11);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF8);
        repeat (8) send_byte(8'hFF);
        repeat (15) send_byte(8'hFF);
        drain();

        // Random groups in blocks; each block is calm or not, and is sometimes drained first.
        next_block = 0;
        while (beats_in < 1360)
        begin
            if (beats_in >= next_block)
            begin
                calm = ($urandom_range(0, 3) == 0);
                next_block = beats_in + 200;
                if ($urandom_range(0, 2) == 0)
                    drain();
            end
            first_n  = pick_len();
            second_n = pick_len();
            send_byte({second_n, first_n});
            send_delta(first_n);
            send_delta(second_n);
        end
        calm = 1'b0;

        // Close the list either by an end marker or by a group with no second delta.
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte({4'($urandom_range(0, 15)), 4'h0});
        end
        else
        begin
            first_n = pick_len();
            send_byte({4'h0, first_n});
            send_delta(first_n);
        end

        // Bytes after the end of the list must give nothing.
        repeat (12) send_byte(8'($urandom));
        byte_valid <= 1'b0;

        while (board.pending() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("Decoded %0d input beats: %0d text bytes, %0d identifiers, %0d end markers.",
                 beats_in, board.text_seen, board.ids_seen, board.ends_seen);
        $display("Delta sizes ran from one to fifteen bytes under random gaps and stalls.");
        if (board.errors == 0)
            $display("delta_varlen_id_decoder_top regression: pass");
        else
            $display("delta_varlen_id_decoder_top regression: fail");
        $finish;
    end

endmodule
